// ----- rtl/bcdc_pkg.sv -----
package bcdc_pkg;

  typedef enum logic [3:0] {
    ACT_TICK    = 4'd0,
    ACT_TOUCH   = 4'd1,
    ACT_INC_HR  = 4'd2,
    ACT_INC_MIN = 4'd3,
    ACT_INC_SEC = 4'd4,
    ACT_DEC_HR  = 4'd5,
    ACT_DEC_MIN = 4'd6,
    ACT_DEC_SEC = 4'd7,
    ACT_CLEAR   = 4'd8
  } action_t;

  localparam logic [1:0] REG_ROW_SPLIT  = 2'd0;
  localparam logic [1:0] REG_LEFT_EDGE  = 2'd1;
  localparam logic [1:0] REG_RIGHT_EDGE = 2'd2;

  localparam logic [7:0] ROW_SPLIT_RST  = 8'd115;
  localparam logic [8:0] LEFT_EDGE_RST  = 9'd136;
  localparam logic [8:0] RIGHT_EDGE_RST = 9'd184;

  // BCD digit limits
  localparam logic [3:0] ONES_MAX = 4'd9;
  localparam logic [2:0] TENS_MAX = 3'd5;

  // minutes and seconds come out of reset at 59
  localparam logic [2:0] PAIR_TENS_RST = 3'd5;
  localparam logic [3:0] PAIR_ONES_RST = 4'd9;

  // hours come out of reset and clear at 12
  localparam logic       HOUR_TENS_RST = 1'b1;
  localparam logic [3:0] HOUR_ONES_RST = 4'd2;

  // per-cell command: link lets the carry of the lower neighbor step this cell
  typedef struct packed {
    logic up;
    logic down;
    logic clr;
    logic link;
  } cell_cmd_t;

endpackage

// ----- rtl/bcdc_pair_cell.sv -----
module bcdc_pair_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  bcdc_pkg::cell_cmd_t cmd,
  input  logic              carry_in,
  output logic [2:0]        tens_next,
  output logic [3:0]        ones_next,
  output logic [1:0]        changed,
  output logic              carry_out
);
  import bcdc_pkg::*;

  logic [2:0] tens;
  logic [3:0] ones;
  logic       step_up;

  assign step_up = cmd.up | (cmd.link & carry_in);

  always_comb begin
    tens_next = tens;
    ones_next = ones;
    priority if (cmd.clr) begin
      tens_next = '0;
      ones_next = '0;
    end else if (step_up) begin
      if (ones >= ONES_MAX) begin
        ones_next = '0;
        tens_next = (tens >= TENS_MAX) ? 3'd0 : tens + 3'd1;
      end else begin
        ones_next = ones + 4'd1;
      end
    end else if (cmd.down) begin
      if (ones == 4'd0 || ones > ONES_MAX) begin
        ones_next = ONES_MAX;
        tens_next = (tens == 3'd0 || tens > TENS_MAX) ? TENS_MAX : tens - 3'd1;
      end else begin
        ones_next = ones - 4'd1;
      end
    end else begin
      tens_next = tens;
    end
  end

  // wrap to 00 on the way up hands a carry to the next cell
  assign carry_out = step_up && !cmd.clr && tens_next == 3'd0 && ones_next == 4'd0;
  assign changed   = {tens_next != tens, ones_next != ones};

  always_ff @(posedge clk) begin
    if (rst) begin
      tens <= PAIR_TENS_RST;
      ones <= PAIR_ONES_RST;
    end else if (en) begin
      tens <= tens_next;
      ones <= ones_next;
    end
  end

endmodule

// ----- rtl/bcdc_hour_cell.sv -----
module bcdc_hour_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  bcdc_pkg::cell_cmd_t cmd,
  input  logic              carry_in,
  output logic              tens_next,
  output logic [3:0]        ones_next,
  output logic [1:0]        changed
);
  import bcdc_pkg::*;

  logic       tens;
  logic [3:0] ones;
  logic       step_up;

  assign step_up = cmd.up | (cmd.link & carry_in);

  always_comb begin
    tens_next = tens;
    ones_next = ones;
    priority if (cmd.clr) begin
      tens_next = HOUR_TENS_RST;
      ones_next = HOUR_ONES_RST;
    end else if (step_up) begin
      if (tens) begin
        // 12 rolls over to 1
        if (ones >= 4'd2) begin
          tens_next = 1'b0;
          ones_next = 4'd1;
        end else begin
          ones_next = ones + 4'd1;
        end
      end else if (ones >= ONES_MAX) begin
        tens_next = 1'b1;
        ones_next = 4'd0;
      end else begin
        ones_next = ones + 4'd1;
      end
    end else if (cmd.down) begin
      if (ones == 4'd1) begin
        if (!tens) begin
          tens_next = HOUR_TENS_RST;
          ones_next = HOUR_ONES_RST;
        end else begin
          ones_next = 4'd0;
        end
      end else if (ones == 4'd0) begin
        tens_next = 1'b0;
        ones_next = ONES_MAX;
      end else begin
        ones_next = ones - 4'd1;
      end
    end else begin
      tens_next = tens;
    end
  end

  assign changed = {tens_next != tens, ones_next != ones};

  always_ff @(posedge clk) begin
    if (rst) begin
      tens <= HOUR_TENS_RST;
      ones <= HOUR_ONES_RST;
    end else if (en) begin
      tens <= tens_next;
      ones <= ones_next;
    end
  end

endmodule

// ----- rtl/bcd_twelve_hour_clock_setter.sv -----
// A result is registered at the edge that accepts its item.
// Throughput: one item per cycle while item_stall is low; the seconds carry
// ripples through the seconds, minutes and hours cells within that cycle.
// The input stalls only while a result waits and the output side stalls.
// Reset: time 12:59:59, touch registers 115 / 136 / 184, no result pending.
module bcd_twelve_hour_clock_setter (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [3:0] action,
  input  logic [8:0] touch_x,
  input  logic [7:0] touch_y,
  output logic       result_valid,
  input  logic       result_stall,
  output logic       hour_tens,
  output logic [3:0] hour_ones,
  output logic [2:0] minute_tens,
  output logic [3:0] minute_ones,
  output logic [2:0] second_tens,
  output logic [3:0] second_ones,
  output logic [5:0] changed_digits,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data
);
  import bcdc_pkg::*;

  logic [7:0] row_split;
  logic [8:0] left_edge;
  logic [8:0] right_edge;

  cell_cmd_t  sec_cmd, min_cmd, hr_cmd;
  logic       item_acc;
  logic       upper_row;
  logic       sec_carry, min_carry;
  logic [2:0] sec_tens_next, min_tens_next;
  logic [3:0] sec_ones_next, min_ones_next, hr_ones_next;
  logic       hr_tens_next;
  logic [1:0] sec_changed, min_changed, hr_changed;

  assign item_stall = result_valid & result_stall;
  assign item_acc   = item_valid & ~item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_split  <= ROW_SPLIT_RST;
      left_edge  <= LEFT_EDGE_RST;
      right_edge <= RIGHT_EDGE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_SPLIT:  row_split  <= cfg_data[7:0];
        REG_LEFT_EDGE:  left_edge  <= cfg_data;
        REG_RIGHT_EDGE: right_edge <= cfg_data;
        default: ;
      endcase
    end
  end

  assign upper_row = touch_y <= row_split;

  // decode the item into one command per cell
  always_comb begin
    sec_cmd = '0;
    min_cmd = '0;
    hr_cmd  = '0;
    unique case (action)
      ACT_TICK: begin
        sec_cmd.up   = 1'b1;
        min_cmd.link = 1'b1;
        hr_cmd.link  = 1'b1;
      end
      ACT_TOUCH: begin
        // the rows treat x on the right edge differently; hours test first
        if (upper_row) begin
          priority if (touch_x <= left_edge) hr_cmd.up = 1'b1;
          else if (touch_x >= right_edge) sec_cmd.up = 1'b1;
          else min_cmd.up = 1'b1;
        end else begin
          priority if (touch_x <= left_edge) hr_cmd.down = 1'b1;
          else if (touch_x <= right_edge) min_cmd.down = 1'b1;
          else sec_cmd.down = 1'b1;
        end
      end
      ACT_INC_HR:  hr_cmd.up    = 1'b1;
      ACT_INC_MIN: min_cmd.up   = 1'b1;
      ACT_INC_SEC: sec_cmd.up   = 1'b1;
      ACT_DEC_HR:  hr_cmd.down  = 1'b1;
      ACT_DEC_MIN: min_cmd.down = 1'b1;
      ACT_DEC_SEC: sec_cmd.down = 1'b1;
      ACT_CLEAR: begin
        sec_cmd.clr = 1'b1;
        min_cmd.clr = 1'b1;
        hr_cmd.clr  = 1'b1;
      end
      default: ;
    endcase
  end

  bcdc_pair_cell u_sec (
    .clk       (clk),
    .rst       (rst),
    .en        (item_acc),
    .cmd       (sec_cmd),
    .carry_in  (1'b0),
    .tens_next (sec_tens_next),
    .ones_next (sec_ones_next),
    .changed   (sec_changed),
    .carry_out (sec_carry)
  );

  bcdc_pair_cell u_min (
    .clk       (clk),
    .rst       (rst),
    .en        (item_acc),
    .cmd       (min_cmd),
    .carry_in  (sec_carry),
    .tens_next (min_tens_next),
    .ones_next (min_ones_next),
    .changed   (min_changed),
    .carry_out (min_carry)
  );

  bcdc_hour_cell u_hr (
    .clk       (clk),
    .rst       (rst),
    .en        (item_acc),
    .cmd       (hr_cmd),
    .carry_in  (min_carry),
    .tens_next (hr_tens_next),
    .ones_next (hr_ones_next),
    .changed   (hr_changed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (item_acc) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_acc) begin
      hour_tens      <= hr_tens_next;
      hour_ones      <= hr_ones_next;
      minute_tens    <= min_tens_next;
      minute_ones    <= min_ones_next;
      second_tens    <= sec_tens_next;
      second_ones    <= sec_ones_next;
      changed_digits <= {hr_changed, min_changed, sec_changed};
    end
  end

  a_acc_gives_result : assert property (@(posedge clk) disable iff (rst)
    item_acc |=> result_valid)
    else $error("accepted item produced no result");

  a_hour_range : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((!hour_tens && hour_ones >= 4'd1 && hour_ones <= 4'd9) ||
                      (hour_tens && hour_ones <= 4'd2)))
    else $error("hour left the 1..12 range");

  a_min_sec_range : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (minute_tens <= TENS_MAX && minute_ones <= ONES_MAX &&
                      second_tens <= TENS_MAX && second_ones <= ONES_MAX))
    else $error("minute or second digit out of range");

  a_clear_result : assert property (@(posedge clk) disable iff (rst)
    item_acc && action == ACT_CLEAR |=>
      hour_tens && hour_ones == 4'd2 && minute_tens == 3'd0 && minute_ones == 4'd0 &&
      second_tens == 3'd0 && second_ones == 4'd0)
    else $error("clear did not give 12:00:00");

  a_no_change_unused : assert property (@(posedge clk) disable iff (rst)
    item_acc && action > ACT_CLEAR |=> changed_digits == 6'd0)
    else $error("unused action changed digits");

endmodule
